// ----- hdl/fhi_pkg.sv -----
// Shared types, constants and code tables of the fixed-Huffman inflate core.
`default_nettype none
package fhi_pkg;

  localparam int unsigned WinBits   = 15;
  localparam int unsigned WinDepth  = 1 << WinBits;
  localparam int unsigned OutBytes  = 8;
  localparam int unsigned OutCntW   = 4;
  localparam int unsigned CodeW     = 13;

  typedef enum logic [5:0] {
    PH_HEADER     = 6'b000001,
    PH_SYMBOL     = 6'b000010,
    PH_LEN_EXTRA  = 6'b000100,
    PH_DIST_CODE  = 6'b001000,
    PH_DIST_EXTRA = 6'b010000,
    PH_DONE       = 6'b100000
  } phase_e;

  localparam logic [2:0] ErrNone     = 3'd0;
  localparam logic [2:0] ErrStored   = 3'd1;
  localparam logic [2:0] ErrDynamic  = 3'd2;
  localparam logic [2:0] ErrReserved = 3'd3;
  localparam logic [2:0] ErrBadCode  = 3'd4;
  localparam logic [2:0] ErrBadDist  = 3'd5;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [3:0]       held;
    phase_e           phase;
    logic [8:0]       mlen;
    logic [4:0]       pcode;
    logic             fin;
    logic [2:0]       err;
  } dec_st_t;

  localparam dec_st_t DecReset = '{code: '0, held: '0, phase: PH_HEADER, mlen: '0,
                                   pcode: '0, fin: 1'b0, err: ErrNone};

  typedef struct packed {
    logic        lit;
    logic [7:0]  lit_val;
    logic        copy;
    logic [15:0] cp_dist;
    logic        eob;
  } dec_ev_t;

  function automatic logic [8:0] len_base(input logic [4:0] i);
    case (i)
      5'd0: len_base = 9'd3;    5'd1: len_base = 9'd4;    5'd2: len_base = 9'd5;
      5'd3: len_base = 9'd6;    5'd4: len_base = 9'd7;    5'd5: len_base = 9'd8;
      5'd6: len_base = 9'd9;    5'd7: len_base = 9'd10;   5'd8: len_base = 9'd11;
      5'd9: len_base = 9'd13;   5'd10: len_base = 9'd15;  5'd11: len_base = 9'd17;
      5'd12: len_base = 9'd19;  5'd13: len_base = 9'd23;  5'd14: len_base = 9'd27;
      5'd15: len_base = 9'd31;  5'd16: len_base = 9'd35;  5'd17: len_base = 9'd43;
      5'd18: len_base = 9'd51;  5'd19: len_base = 9'd59;  5'd20: len_base = 9'd67;
      5'd21: len_base = 9'd83;  5'd22: len_base = 9'd99;  5'd23: len_base = 9'd115;
      5'd24: len_base = 9'd131; 5'd25: len_base = 9'd163; 5'd26: len_base = 9'd195;
      5'd27: len_base = 9'd227; 5'd28: len_base = 9'd258;
      default: len_base = 9'd0;
    endcase
  endfunction

  function automatic logic [2:0] len_extra(input logic [4:0] i);
    if (i >= 5'd8 && i <= 5'd27) len_extra = 3'(((i - 5'd8) >> 2) + 5'd1);
    else len_extra = 3'd0;
  endfunction

  function automatic logic [15:0] dist_base(input logic [4:0] i);
    case (i)
      5'd0: dist_base = 16'd1;      5'd1: dist_base = 16'd2;
      5'd2: dist_base = 16'd3;      5'd3: dist_base = 16'd4;
      5'd4: dist_base = 16'd5;      5'd5: dist_base = 16'd7;
      5'd6: dist_base = 16'd9;      5'd7: dist_base = 16'd13;
      5'd8: dist_base = 16'd17;     5'd9: dist_base = 16'd25;
      5'd10: dist_base = 16'd33;    5'd11: dist_base = 16'd49;
      5'd12: dist_base = 16'd65;    5'd13: dist_base = 16'd97;
      5'd14: dist_base = 16'd129;   5'd15: dist_base = 16'd193;
      5'd16: dist_base = 16'd257;   5'd17: dist_base = 16'd385;
      5'd18: dist_base = 16'd513;   5'd19: dist_base = 16'd769;
      5'd20: dist_base = 16'd1025;  5'd21: dist_base = 16'd1537;
      5'd22: dist_base = 16'd2049;  5'd23: dist_base = 16'd3073;
      5'd24: dist_base = 16'd4097;  5'd25: dist_base = 16'd6145;
      5'd26: dist_base = 16'd8193;  5'd27: dist_base = 16'd12289;
      5'd28: dist_base = 16'd16385; 5'd29: dist_base = 16'd24577;
      default: dist_base = 16'd0;
    endcase
  endfunction

  function automatic logic [3:0] dist_extra(input logic [4:0] i);
    if (i >= 5'd4 && i <= 5'd29) dist_extra = 4'((i - 5'd2) >> 1);
    else dist_extra = 4'd0;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/fhi_bitdec.sv -----
// Single-bit step of the header, symbol, length and distance decoder.
`default_nettype none
module fhi_bitdec (
  input  fhi_pkg::dec_st_t st_i,
  input  wire logic        bit_i,
  input  wire logic [15:0] seen_i,
  output fhi_pkg::dec_st_t st_o,
  output fhi_pkg::dec_ev_t ev_o
);
  import fhi_pkg::*;

  logic [CodeW-1:0] sh_n;
  logic [CodeW-1:0] or_n;
  logic [3:0]       held_n;
  logic [7:0]       t8;
  logic [15:0]      dist_v;

  assign sh_n   = {st_i.code[CodeW-2:0], bit_i};
  assign or_n   = st_i.code | (CodeW'(bit_i) << st_i.held);
  assign held_n = st_i.held + 4'd1;
  assign t8     = sh_n[7:0] - 8'hC0 + 8'd23;

  always_comb begin
    st_o   = st_i;
    ev_o   = '0;
    dist_v = '0;
    if (st_i.err == ErrNone) begin
      case (st_i.phase)
        PH_HEADER: begin
          st_o.code = or_n;
          st_o.held = held_n;
          if (held_n == 4'd3) begin
            st_o.fin  = or_n[0];
            st_o.code = '0;
            st_o.held = '0;
            case (or_n[2:1])
              2'd1: st_o.phase = PH_SYMBOL;
              2'd0: st_o.err = ErrStored;
              2'd2: st_o.err = ErrDynamic;
              default: st_o.err = ErrReserved;
            endcase
          end
        end
        PH_SYMBOL: begin
          st_o.code = sh_n;
          st_o.held = held_n;
          if (held_n == 4'd7 && sh_n <= CodeW'(8'h17)) begin
            st_o.code = '0;
            st_o.held = '0;
            if (sh_n == '0) begin
              ev_o.eob   = 1'b1;
              st_o.phase = st_i.fin ? PH_DONE : PH_HEADER;
            end else begin
              st_o.pcode = 5'(sh_n - CodeW'(1));
              st_o.mlen  = len_base(5'(sh_n - CodeW'(1)));
              st_o.phase = (len_extra(5'(sh_n - CodeW'(1))) != 3'd0) ?
                           PH_LEN_EXTRA : PH_DIST_CODE;
            end
          end else if (held_n == 4'd8 && sh_n <= CodeW'(8'hBF)) begin
            st_o.code   = '0;
            st_o.held   = '0;
            ev_o.lit    = 1'b1;
            ev_o.lit_val = sh_n[7:0] - 8'h30;
          end else if (held_n == 4'd8 && sh_n <= CodeW'(8'hC7)) begin
            st_o.code = '0;
            st_o.held = '0;
            if (t8 > 8'd28) begin
              st_o.err = ErrBadCode;
            end else begin
              st_o.pcode = t8[4:0];
              st_o.mlen  = len_base(t8[4:0]);
              st_o.phase = (len_extra(t8[4:0]) != 3'd0) ? PH_LEN_EXTRA : PH_DIST_CODE;
            end
          end else if (held_n >= 4'd9) begin
            st_o.code    = '0;
            st_o.held    = '0;
            ev_o.lit     = 1'b1;
            ev_o.lit_val = sh_n[7:0];
          end
        end
        PH_LEN_EXTRA: begin
          st_o.code = or_n;
          st_o.held = held_n;
          if (held_n >= {1'b0, len_extra(st_i.pcode)}) begin
            st_o.mlen  = st_i.mlen + or_n[8:0];
            st_o.code  = '0;
            st_o.held  = '0;
            st_o.phase = PH_DIST_CODE;
          end
        end
        PH_DIST_CODE: begin
          st_o.code = sh_n;
          st_o.held = held_n;
          if (held_n == 4'd5) begin
            st_o.code = '0;
            st_o.held = '0;
            if (sh_n[4:0] > 5'd29) begin
              st_o.err = ErrBadCode;
            end else if (dist_extra(sh_n[4:0]) != 4'd0) begin
              st_o.pcode = sh_n[4:0];
              st_o.phase = PH_DIST_EXTRA;
            end else begin
              dist_v = dist_base(sh_n[4:0]);
              if (dist_v > seen_i) begin
                st_o.err = ErrBadDist;
              end else begin
                ev_o.copy    = 1'b1;
                ev_o.cp_dist = dist_v;
                st_o.phase   = PH_SYMBOL;
              end
            end
          end
        end
        PH_DIST_EXTRA: begin
          st_o.code = or_n;
          st_o.held = held_n;
          if (held_n >= dist_extra(st_i.pcode)) begin
            st_o.code = '0;
            st_o.held = '0;
            dist_v = dist_base(st_i.pcode) + {3'b000, or_n};
            if (dist_v > seen_i) begin
              st_o.err = ErrBadDist;
            end else begin
              ev_o.copy    = 1'b1;
              ev_o.cp_dist = dist_v;
              st_o.phase   = PH_SYMBOL;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/fixed_huffman_inflate_core.sv -----
// Top level of the fixed-Huffman inflate core with its history memory.
// Each compressed word passes through an accept state, bit decoding (one bit per cycle), a
// dispatch state, in which a literal is also written to history, and a load of the output
// register. A match copy reads each copied byte from history and then writes it back, and loads
// the output register once per further result. Results leave through an output register; each
// result waits there until taken, and the core holds while the register is full.
// History is a 32768-entry single-port-write, single-port-read memory with registered read data;
// no clearing pass is needed.
`default_nettype none
module fixed_huffman_inflate_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // in_byte
  input  wire logic        s_axis_tuser,   // stream_start
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // out_bytes[63:0], out_count[67:64], zero pad
  output logic             m_axis_tlast,   // run_last
  output logic [4:0]       m_axis_tuser    // block_end, final_block, error_code[4:2]
);
  import fhi_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_BIT  = 6'b000010,
    S_SEL  = 6'b000100,
    S_RD   = 6'b001000,
    S_WR   = 6'b010000,
    S_PUSH = 6'b100000
  } state_e;

  state_e state_q, state_d;
  dec_st_t dst_q, dst_d, dst_step;
  dec_ev_t ev_step;
  logic [7:0] byte_q, byte_d;
  logic [2:0] bcnt_q, bcnt_d;
  logic lit_q, lit_d, copy_q, copy_d, eob_q, eob_d, last_q, last_d;
  logic [7:0] litv_q, litv_d;
  logic [15:0] dist_q, dist_d;
  logic [WinBits-1:0] wp_q, wp_d;
  logic [15:0] seen_q, seen_d;
  logic [8:0] rem_q, rem_d;
  logic [63:0] buf_q, buf_d;
  logic [OutCntW-1:0] cnt_q, cnt_d;
  logic ov_q, ov_d;
  logic [63:0] ob_q, ob_d;
  logic [OutCntW-1:0] oc_q, oc_d;
  logic [5:0] ou_q, ou_d;

  logic [7:0] mem [WinDepth];
  logic [7:0] rdata_q;
  logic [WinBits-1:0] raddr;
  logic we;
  logic [7:0] wdata;

  fhi_bitdec u_bitdec (
    .st_i  (dst_q),
    .bit_i (byte_q[bcnt_q]),
    .seen_i(seen_q),
    .st_o  (dst_step),
    .ev_o  (ev_step)
  );

  assign raddr = wp_q - dist_q[WinBits-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wp_q] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'b0000, oc_q, ob_q};
  assign m_axis_tlast  = ou_q[0];
  assign m_axis_tuser  = ou_q[5:1];

  always_comb begin
    state_d = state_q;
    dst_d   = dst_q;
    byte_d  = byte_q;
    bcnt_d  = bcnt_q;
    lit_d   = lit_q;
    litv_d  = litv_q;
    copy_d  = copy_q;
    dist_d  = dist_q;
    eob_d   = eob_q;
    last_d  = last_q;
    wp_d    = wp_q;
    seen_d  = seen_q;
    rem_d   = rem_q;
    buf_d   = buf_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q & ~m_axis_tready;
    ob_d    = ob_q;
    oc_d    = oc_q;
    ou_d    = ou_q;
    we      = 1'b0;
    wdata   = rdata_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser) begin
            dst_d  = DecReset;
            wp_d   = '0;
            seen_d = '0;
          end
          byte_d  = s_axis_tdata;
          bcnt_d  = '0;
          lit_d   = 1'b0;
          copy_d  = 1'b0;
          eob_d   = 1'b0;
          state_d = S_BIT;
        end
      end
      S_BIT: begin
        dst_d  = dst_step;
        bcnt_d = bcnt_q + 3'd1;
        if (ev_step.lit) begin
          lit_d  = 1'b1;
          litv_d = ev_step.lit_val;
        end
        if (ev_step.copy) begin
          copy_d = 1'b1;
          dist_d = ev_step.cp_dist;
          rem_d  = dst_q.mlen;
        end
        if (ev_step.eob) begin
          eob_d = 1'b1;
        end
        if (bcnt_q == 3'd7) begin
          state_d = S_SEL;
        end
      end
      S_SEL: begin
        buf_d = '0;
        cnt_d = '0;
        if (lit_q) begin
          we     = 1'b1;
          wdata  = litv_q;
          wp_d   = wp_q + 1'b1;
          seen_d = (seen_q < 16'(WinDepth)) ? seen_q + 16'd1 : seen_q;
          buf_d  = {56'd0, litv_q};
          cnt_d  = OutCntW'(1);
          last_d = 1'b1;
          state_d = S_PUSH;
        end else if (copy_q) begin
          state_d = S_RD;
        end else begin
          last_d  = 1'b1;
          state_d = S_PUSH;
        end
      end
      S_RD: begin
        state_d = S_WR;
      end
      S_WR: begin
        we     = 1'b1;
        wp_d   = wp_q + 1'b1;
        seen_d = (seen_q < 16'(WinDepth)) ? seen_q + 16'd1 : seen_q;
        buf_d  = buf_q | ({56'd0, rdata_q} << {cnt_q[2:0], 3'b000});
        cnt_d  = cnt_q + OutCntW'(1);
        rem_d  = rem_q - 9'd1;
        if (cnt_d == OutCntW'(OutBytes) || rem_d == 9'd0) begin
          last_d  = (rem_d == 9'd0);
          state_d = S_PUSH;
        end else begin
          state_d = S_RD;
        end
      end
      S_PUSH: begin
        if (!ov_q || m_axis_tready) begin
          ov_d  = 1'b1;
          ob_d  = buf_q;
          oc_d  = cnt_q;
          ou_d  = {dst_q.err, dst_q.fin, eob_q, last_q};
          buf_d = '0;
          cnt_d = '0;
          state_d = last_q ? S_IDLE : S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dst_q       <= DecReset;
      wp_q        <= '0;
      seen_q      <= '0;
      ov_q        <= 1'b0;
      bcnt_q      <= '0;
      lit_q       <= 1'b0;
      copy_q      <= 1'b0;
      eob_q       <= 1'b0;
      last_q      <= 1'b0;
      rem_q       <= '0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      dst_q   <= dst_d;
      wp_q    <= wp_d;
      seen_q  <= seen_d;
      ov_q    <= ov_d;
      bcnt_q  <= bcnt_d;
      lit_q   <= lit_d;
      copy_q  <= copy_d;
      eob_q   <= eob_d;
      last_q  <= last_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    litv_q <= litv_d;
    dist_q <= dist_d;
    buf_q  <= buf_d;
    ob_q   <= ob_d;
    oc_q   <= oc_d;
    ou_q   <= ou_d;
  end

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the fixed-Huffman inflate core: encoded streams in, bytes checked.
`timescale 1ns / 1ps
module tb_top;
  import fhi_pkg::*;

  localparam int HistDepth = 32768;
  localparam int MaxRes    = 34;
  localparam int LenBase[29] = '{3, 4, 5, 6, 7, 8, 9, 10, 11, 13, 15, 17, 19, 23, 27, 31,
                                 35, 43, 51, 59, 67, 83, 99, 115, 131, 163, 195, 227, 258};
  localparam int LenExt[29]  = '{0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 2, 2,
                                 3, 3, 3, 3, 4, 4, 4, 4, 5, 5, 5, 5, 0};
  localparam int DistBase[30] = '{1, 2, 3, 4, 5, 7, 9, 13, 17, 25, 33, 49, 65, 97, 129, 193,
                                  257, 385, 513, 769, 1025, 1537, 2049, 3073, 4097, 6145,
                                  8193, 12289, 16385, 24577};
  localparam int DistExt[30]  = '{0, 0, 0, 0, 1, 1, 2, 2, 3, 3, 4, 4, 5, 5, 6, 6,
                                  7, 7, 8, 8, 9, 9, 10, 10, 11, 11, 12, 12, 13, 13};

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        last;
    logic        eob;
    logic        fin;
    logic [2:0]  err;
  } out_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [4:0]  m_axis_tuser;

  fixed_huffman_inflate_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // decoder model state
  logic [7:0]  hist [HistDepth];
  int          wr_pos, hist_fill, shreg, nbits, match_len, pend_code;
  phase_e      phase;
  logic        fin_flag, eob_seen;
  logic [2:0]  err_code;
  logic [63:0] acc_data [MaxRes];
  int          acc_cnt  [MaxRes];
  int          n_acc;

  out_word_t   expected_words [$];
  int          errors = 0;
  int          n_sent = 0;
  bit          calm = 0;

  // stream builder state
  bit          bitq [$];
  int          enc_fill;

  function automatic void clear_bits();
    shreg = 0;
    nbits = 0;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    hist[wr_pos] = b;
    wr_pos = (wr_pos + 1) % HistDepth;
    if (hist_fill < HistDepth) hist_fill++;
    if (n_acc == 0 || acc_cnt[n_acc-1] >= 8) begin
      if (n_acc >= MaxRes) return;
      acc_data[n_acc] = '0;
      acc_cnt[n_acc] = 0;
      n_acc++;
    end
    acc_data[n_acc-1] |= 64'(b) << (8 * acc_cnt[n_acc-1]);
    acc_cnt[n_acc-1]++;
  endfunction

  function automatic void start_len(input int idx);
    clear_bits();
    pend_code = idx;
    match_len = LenBase[idx];
    phase = (LenExt[idx] != 0) ? PH_LEN_EXTRA : PH_DIST_CODE;
  endfunction

  function automatic void finish_copy(input int dval);
    clear_bits();
    if (dval == 0 || dval > hist_fill) begin
      err_code = ErrBadDist;
      return;
    end
    for (int i = 0; i < match_len; i++) put_byte(hist[(wr_pos + HistDepth - dval) % HistDepth]);
    phase = PH_SYMBOL;
  endfunction

  function automatic void decode_bit(input int b);
    int t;
    if (err_code != ErrNone) return;
    case (phase)
      PH_HEADER: begin
        shreg |= b << nbits;
        nbits++;
        if (nbits == 3) begin
          fin_flag = shreg[0];
          t = (shreg >> 1) & 3;
          clear_bits();
          if (t == 1) phase = PH_SYMBOL;
          else err_code = (t == 0) ? ErrStored : (t == 2) ? ErrDynamic : ErrReserved;
        end
      end
      PH_SYMBOL: begin
        shreg = (shreg << 1) | b;
        nbits++;
        if (nbits == 7 && shreg <= 'h17) begin
          if (shreg == 0) begin
            eob_seen = 1'b1;
            clear_bits();
            phase = fin_flag ? PH_DONE : PH_HEADER;
          end else begin
            start_len(shreg - 1);
          end
        end else if (nbits == 8 && shreg <= 'hBF) begin
          t = shreg - 'h30;
          clear_bits();
          put_byte(8'(t));
        end else if (nbits == 8 && shreg <= 'hC7) begin
          t = shreg - 'hC0 + 23;
          if (t > 28) begin
            clear_bits();
            err_code = ErrBadCode;
          end else begin
            start_len(t);
          end
        end else if (nbits >= 9) begin
          t = (shreg - 'h190 + 144) & 'hFF;
          clear_bits();
          put_byte(8'(t));
        end
      end
      PH_LEN_EXTRA: begin
        shreg |= b << nbits;
        nbits++;
        if (nbits >= LenExt[pend_code]) begin
          match_len = (match_len + shreg) & 'h1FF;
          clear_bits();
          phase = PH_DIST_CODE;
        end
      end
      PH_DIST_CODE: begin
        shreg = (shreg << 1) | b;
        nbits++;
        if (nbits == 5) begin
          t = shreg & 31;
          clear_bits();
          if (t > 29) err_code = ErrBadCode;
          else if (DistExt[t] != 0) begin
            pend_code = t;
            phase = PH_DIST_EXTRA;
          end else finish_copy(DistBase[t]);
        end
      end
      PH_DIST_EXTRA: begin
        shreg |= b << nbits;
        nbits++;
        if (nbits >= DistExt[pend_code]) finish_copy(DistBase[pend_code] + shreg);
      end
      default: ;
    endcase
  endfunction

  function automatic void clear_stream();
    wr_pos = 0;
    hist_fill = 0;
    clear_bits();
    phase = PH_HEADER;
    match_len = 0;
    fin_flag = 1'b0;
    err_code = ErrNone;
    pend_code = 0;
  endfunction

  function automatic void inflate_byte(input logic [7:0] b, input logic start);
    out_word_t w;
    if (start) clear_stream();
    n_acc = 0;
    eob_seen = 1'b0;
    for (int i = 0; i < 8; i++) decode_bit(b[i]);
    if (n_acc == 0) begin
      acc_data[0] = '0;
      acc_cnt[0] = 0;
      n_acc = 1;
    end
    for (int k = 0; k < n_acc; k++) begin
      w.data = acc_data[k];
      w.cnt  = 4'(acc_cnt[k]);
      w.last = (k == n_acc - 1);
      w.eob  = eob_seen;
      w.fin  = fin_flag;
      w.err  = err_code;
      expected_words.insert(expected_words.size(), w);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    inflate_byte(b, start);
    n_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (600) @(posedge clk_i);
  endtask

  // bit packing of encoded streams
  function automatic void push_msb(input int v, input int n);
    for (int i = n - 1; i >= 0; i--) bitq.insert(bitq.size(), v[i]);
  endfunction

  function automatic void push_lsb(input int v, input int n);
    for (int i = 0; i < n; i++) bitq.insert(bitq.size(), v[i]);
  endfunction

  function automatic void put_header(input bit fin, input int btype);
    push_lsb(fin, 1);
    push_lsb(btype, 2);
  endfunction

  function automatic void put_literal(input int v);
    if (v < 144) push_msb('h30 + v, 8);
    else push_msb('h190 + v - 144, 9);
    enc_fill++;
  endfunction

  function automatic void put_symbol(input int sym);
    if (sym < 280) push_msb(sym - 256, 7);
    else push_msb('hC0 + sym - 280, 8);
  endfunction

  function automatic void put_match(input int len, input int dval);
    int idx, dc;
    idx = 28;
    if (len < 258) begin
      idx = 27;
      while (LenBase[idx] > len) idx--;
    end
    put_symbol(257 + idx);
    push_lsb(len - LenBase[idx], LenExt[idx]);
    dc = 29;
    while (DistBase[dc] > dval) dc--;
    push_msb(dc, 5);
    push_lsb(dval - DistBase[dc], DistExt[dc]);
    enc_fill += len;
  endfunction

  task automatic send_stream();
    logic [7:0] b;
    bit first;
    first = 1;
    while (bitq.size() % 8 != 0) bitq.insert(bitq.size(), 1'($urandom_range(0, 1)));
    while (bitq.size() != 0) begin
      for (int i = 0; i < 8; i++) b[i] = bitq.pop_front();
      send_byte(b, first);
      first = 0;
    end
    enc_fill = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : rx_ready
    int stall;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall = 0;
    end else if (stall != 0) begin
      stall--;
      m_axis_tready <= (stall == 0);
    end else if (m_axis_tvalid && m_axis_tready && !calm) begin
      stall = $urandom_range(0, 9);
      m_axis_tready <= (stall == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_words
    out_word_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[63:0], m_axis_tdata[67:64], m_axis_tlast, m_axis_tuser[0],
             m_axis_tuser[1], m_axis_tuser[4:2]};
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word data=%h cnt=%0d", $time, got.data, got.cnt);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          $display("%0t mismatch exp data=%h cnt=%0d last=%b eob=%b fin=%b err=%0d", $time,
                   want.data, want.cnt, want.last, want.eob, want.fin, want.err);
          $display("%0t          got data=%h cnt=%0d last=%b eob=%b fin=%b err=%0d", $time,
                   got.data, got.cnt, got.last, got.eob, got.fin, got.err);
          errors++;
        end
      end
    end
  end

  task automatic test_block_types();
    for (int t = 0; t < 4; t++) begin
      if (t == 1) continue;
      put_header(t[0], t);
      send_stream();
    end
  endtask

  task automatic test_symbols();
    put_header(0, 1);
    put_literal(0);
    put_literal(143);
    put_literal(144);
    put_literal(255);
    put_match(3, 1);
    put_match(258, 4);
    put_match(12, 7);
    put_symbol(256);
    put_header(1, 1);
    put_literal(65);
    put_match(20, 2);
    put_match(60, 30);
    put_match(250, 9);
    put_symbol(256);
    send_stream();
    send_byte(8'hA5, 1'b0);
  endtask

  task automatic test_bad_codes();
    put_header(1, 1);
    put_literal(7);
    put_symbol(286);
    send_stream();
    put_header(1, 1);
    put_literal(9);
    put_symbol(257);
    push_msb(31, 5);
    send_stream();
    put_header(1, 1);
    put_literal(1);
    put_match(3, 24577 + 8191);
    send_stream();
    put_header(1, 1);
    put_match(3, 1);
    send_stream();
  endtask

  task automatic random_stream();
    int nblk, nsym, r, len;
    nblk = $urandom_range(1, 2);
    for (int k = 0; k < nblk; k++) begin
      put_header(k == nblk - 1, 1);
      nsym = $urandom_range(2, 12);
      for (int s = 0; s < nsym; s++) begin
        r = $urandom_range(0, 99);
        if (r < 3) put_symbol($urandom_range(286, 287));
        else if (r < 5) push_msb($urandom_range(30, 31), 5);
        else if (r < 55 || enc_fill == 0) put_literal($urandom_range(0, 255));
        else begin
          len = (r < 60) ? $urandom_range(3, 258) : $urandom_range(3, 24);
          put_match(len, (r < 62) ? enc_fill + 1 : $urandom_range(1, enc_fill < 300 ?
                    enc_fill : 300));
        end
      end
      put_symbol(256);
    end
    send_stream();
  endtask

  task automatic test_random();
    calm = 1;
    for (int i = 0; i < 3; i++) random_stream();
    calm = 0;
    while (n_sent < 110) begin
      if ($urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom), 1'b1);
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'($urandom));
      end else begin
        random_stream();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_block_types();
    test_symbols();
    test_bad_codes();
    drain();
    test_random();
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
